// ----- design/lrupr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrupr_pkg
// Shared constants for the LRU page replacement block: stream payload widths
// and the reset value of the frame count register.
// ----------------------------------------------------------------------------
package lrupr_pkg;

    // input stream: tdata = page_number
    localparam int PAGE_IN_W  = 16;
    localparam int S_TDATA_W  = 16;
    localparam int S_TUSER_W  = 1;

    // output stream: tdata = frame_index, evicted_page, fault_count (zero pad)
    localparam int FRAME_IDX_W = 4;
    localparam int COUNT_W     = 32;
    localparam int M_TDATA_W   = 56;
    localparam int M_TUSER_W   = 2;

    // frame count register
    localparam int FRAMES_CFG_W = 5;
    localparam logic [FRAMES_CFG_W-1:0] FRAMES_RESET = 5'd4;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

endpackage

// ----- design/lru_page_replacement.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_page_replacement
// Least recently used page replacement over a set of page frames, one page
// reference per transfer, one result per reference.
// ----------------------------------------------------------------------------
// The block accepts one page reference every clock cycle while the output
// side does not stall, and returns one result for each through the input
// register and then the result register. The rate is set by the frame state
// loop: the tag compare over all frames, the oldest-frame search and the
// recency rank update are combinational, so the next reference sees the
// updated frames at once. A reference with the clear flag set first empties
// all frames and zeroes the fault count. The frame count register may be
// written only while no reference is in flight; zero acts as one frame and a
// value above MAX_FRAMES acts as MAX_FRAMES. Frame indexes are reported in
// four bits.
// ----------------------------------------------------------------------------
module lru_page_replacement #(
    parameter int MAX_FRAMES = 16,
    parameter int PAGE_BITS  = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // frame count register
    input  logic                                 cfg_wr_en,
    input  logic [lrupr_pkg::FRAMES_CFG_W-1:0]   cfg_wr_data,   // frames_in_use
    // reference stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [lrupr_pkg::S_TDATA_W-1:0]      s_tdata,       // [15:0] page_number
    input  logic [lrupr_pkg::S_TUSER_W-1:0]      s_tuser,       // [0] clear_first
    input  logic                                 s_tlast,       // is_last
    // result stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [3:0] frame_index, [19:4] evicted_page, [51:20] fault_count, [55:52] zero
    output logic [lrupr_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic [lrupr_pkg::M_TUSER_W-1:0]      m_tuser,       // [0] page_fault,
                                                                // [1] evicted_valid
    output logic                                 m_tlast        // final_total
);

    import lrupr_pkg::*;

    localparam int IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int RW = IW;
    localparam int CW = $clog2(MAX_FRAMES + 1);
    localparam int XW = IW + CW;
    localparam logic [RW-1:0] RANK_MAX = RW'(MAX_FRAMES - 1);
    localparam logic [CW-1:0] F_MAX    = CW'(MAX_FRAMES);

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    logic [FRAMES_CFG_W-1:0] frames_reg;
    logic [CW-1:0]           f_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_reg <= FRAMES_RESET;
        end
        else if (cfg_wr_en)
        begin
            frames_reg <= cfg_wr_data;
        end
    end

    always_comb
    begin
        priority if (frames_reg == '0)
        begin
            f_eff = CW'(1);
        end
        else if (32'(frames_reg) > 32'(MAX_FRAMES))
        begin
            f_eff = F_MAX;
        end
        else
        begin
            f_eff = CW'(frames_reg);
        end
    end

    // ------------------------------------------------------------------
    // input register and output handshake
    // ------------------------------------------------------------------
    logic                  s1_valid_reg;
    logic [PAGE_BITS-1:0]  s1_page_reg;
    logic                  s1_clr_reg;
    logic                  s1_last_reg;
    logic                  advance;
    logic [PAGE_BITS+PAGE_IN_W-1:0] page_wide;

    assign advance  = s1_valid_reg && (!m_tvalid || m_tready);
    assign s_tready = !s1_valid_reg || advance;
    assign page_wide = {{PAGE_BITS{1'b0}}, s_tdata[PAGE_IN_W-1:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            s1_page_reg <= page_wide[PAGE_BITS-1:0];
            s1_clr_reg  <= s_tuser[0];
            s1_last_reg <= s_tlast;
        end
    end

    // ------------------------------------------------------------------
    // frame state
    // ------------------------------------------------------------------
    logic [PAGE_BITS-1:0]  frame_page_reg  [MAX_FRAMES];
    logic [MAX_FRAMES-1:0] frame_valid_reg;
    logic [RW-1:0]         rank_reg        [MAX_FRAMES];
    logic [IW-1:0]         fill_reg;
    logic [COUNT_W-1:0]    fault_total_reg;

    logic [MAX_FRAMES-1:0] eff_valid;
    logic [RW-1:0]         eff_rank  [MAX_FRAMES];
    logic [IW-1:0]         eff_fill;
    logic [COUNT_W-1:0]    eff_total;
    logic [MAX_FRAMES-1:0] cand;
    logic [MAX_FRAMES-1:0] match;
    logic [MAX_FRAMES-1:0] hit_oh;
    logic [MAX_FRAMES-1:0] oldest;
    logic [MAX_FRAMES-1:0] p_oh;
    logic [MAX_FRAMES-1:0] sel_oh;
    logic                  hit;
    logic                  p_free;
    logic                  do_fill;
    logic                  do_repl;
    logic [IW-1:0]         p_idx;
    logic [IW-1:0]         p_step;
    logic [IW-1:0]         k_idx;
    logic [RW-1:0]         sel_rank;
    logic [PAGE_BITS-1:0]  sel_page;
    logic [PAGE_BITS-1:0]  ev_page;

    logic [PAGE_BITS-1:0]  frame_page_next [MAX_FRAMES];
    logic [MAX_FRAMES-1:0] frame_valid_next;
    logic [RW-1:0]         rank_next       [MAX_FRAMES];
    logic [IW-1:0]         fill_next;
    logic [COUNT_W-1:0]    fault_total_next;

    always_comb
    begin
        eff_fill  = s1_clr_reg ? '0 : fill_reg;
        eff_total = s1_clr_reg ? '0 : fault_total_reg;
        for (int i = 0; i < MAX_FRAMES; i++)
        begin
            eff_valid[i] = !s1_clr_reg && frame_valid_reg[i];
            eff_rank[i]  = s1_clr_reg ? '0 : rank_reg[i];
            cand[i]      = eff_valid[i] && (32'(i) < 32'(f_eff));
            match[i]     = cand[i] && (frame_page_reg[i] == s1_page_reg);
        end
        hit    = |match;
        hit_oh = match & (~match + MAX_FRAMES'(1));

        // oldest candidate, lowest frame on equal ranks
        for (int i = 0; i < MAX_FRAMES; i++)
        begin
            oldest[i] = cand[i];
            for (int j = 0; j < MAX_FRAMES; j++)
            begin
                if (cand[j] && (j < i) && !(eff_rank[i] > eff_rank[j]))
                begin
                    oldest[i] = 1'b0;
                end
                if (cand[j] && (j > i) && (eff_rank[j] > eff_rank[i]))
                begin
                    oldest[i] = 1'b0;
                end
            end
        end

        // fill pointer falls back to frame zero when out of range
        p_idx  = (XW'(eff_fill) < XW'(f_eff)) ? eff_fill : '0;
        p_step = (XW'(p_idx) + XW'(1) == XW'(f_eff)) ? '0 : IW'(XW'(p_idx) + XW'(1));
        for (int i = 0; i < MAX_FRAMES; i++)
        begin
            p_oh[i] = (32'(p_idx) == 32'(i));
        end
        p_free  = |(p_oh & ~eff_valid);
        do_fill = !hit && p_free;
        do_repl = !hit && !p_free;

        priority if (hit)
        begin
            sel_oh = hit_oh;
        end
        else if (do_fill)
        begin
            sel_oh = p_oh;
        end
        else
        begin
            sel_oh = oldest;
        end

        k_idx    = '0;
        sel_rank = '0;
        sel_page = '0;
        for (int i = 0; i < MAX_FRAMES; i++)
        begin
            if (sel_oh[i])
            begin
                k_idx    = k_idx | IW'(i);
                sel_rank = sel_rank | eff_rank[i];
                sel_page = sel_page | frame_page_reg[i];
            end
        end
        ev_page = do_repl ? sel_page : '0;

        // age frames younger than the touched one, make it the newest
        for (int i = 0; i < MAX_FRAMES; i++)
        begin
            rank_next[i]       = eff_rank[i];
            frame_page_next[i] = frame_page_reg[i];
            if (sel_oh[i])
            begin
                rank_next[i] = '0;
                if (!hit)
                begin
                    frame_page_next[i] = s1_page_reg;
                end
            end
            else if (eff_valid[i] && (do_fill || (eff_rank[i] < sel_rank)) &&
                     (eff_rank[i] != RANK_MAX))
            begin
                rank_next[i] = eff_rank[i] + RW'(1);
            end
        end
        frame_valid_next = eff_valid | sel_oh;

        priority if (hit)
        begin
            fill_next = eff_fill;
        end
        else if (do_fill)
        begin
            fill_next = p_step;
        end
        else
        begin
            fill_next = k_idx;
        end

        fault_total_next = (!hit && (eff_total != COUNT_MAX)) ?
                           eff_total + COUNT_W'(1) : eff_total;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_valid_reg <= '0;
            fill_reg        <= '0;
            fault_total_reg <= '0;
            for (int i = 0; i < MAX_FRAMES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else if (advance)
        begin
            frame_valid_reg <= frame_valid_next;
            fill_reg        <= fill_next;
            fault_total_reg <= fault_total_next;
            for (int i = 0; i < MAX_FRAMES; i++)
            begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < MAX_FRAMES; i++)
            begin
                frame_page_reg[i] <= frame_page_next[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    logic                  out_valid_reg;
    logic                  out_fault_reg;
    logic [FRAME_IDX_W-1:0] out_frame_reg;
    logic                  out_ev_valid_reg;
    logic [PAGE_IN_W-1:0]  out_ev_page_reg;
    logic [COUNT_W-1:0]    out_count_reg;
    logic                  out_last_reg;
    logic [IW+FRAME_IDX_W-1:0]    k_wide;
    logic [PAGE_BITS+PAGE_IN_W-1:0] ev_wide;

    assign k_wide  = {{FRAME_IDX_W{1'b0}}, k_idx};
    assign ev_wide = {{PAGE_IN_W{1'b0}}, ev_page};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_fault_reg    <= !hit;
            out_frame_reg    <= k_wide[FRAME_IDX_W-1:0];
            out_ev_valid_reg <= do_repl;
            out_ev_page_reg  <= ev_wide[PAGE_IN_W-1:0];
            out_count_reg    <= fault_total_next;
            out_last_reg     <= s1_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - FRAME_IDX_W - PAGE_IN_W - COUNT_W){1'b0}},
                       out_count_reg, out_ev_page_reg, out_frame_reg};
    assign m_tuser  = {out_ev_valid_reg, out_fault_reg};
    assign m_tlast  = out_last_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_held_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |=> (s1_valid_reg && $stable(s1_page_reg)))
        else $error("pending reference lost while output stalled");

    a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !s1_clr_reg) |=> (fault_total_reg >= $past(fault_total_reg)))
        else $error("fault total decreased without clear");

    a_fill_marks_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && do_fill) |=> ((frame_valid_reg & $past(sel_oh)) != '0))
        else $error("filled frame not marked valid");

    a_single_select: assert property (@(posedge clk) disable iff (!rst_n)
        advance |-> $onehot(sel_oh))
        else $error("frame select is not one-hot");

    a_evict_needs_fault: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |-> (m_tuser[0] && m_tdata[51:20] != '0))
        else $error("eviction reported without a counted fault");

endmodule

// ----- test/tb_lru_page_replacement.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_page_replacement
// Self-checking bench for the LRU page replacement block. A clocked driver
// sends page references from a queue that the stimulus fills phase by phase.
// A frame-table predictor computes the expected result of every accepted
// reference, and a monitor compares each output transfer field by field.
// The frame count register is rewritten between phases while the block is
// idle. Some phases clear first and some keep the old frames, so a changed
// frame count acts on frames that are already filled.
// ----------------------------------------------------------------------------
module tb_lru_page_replacement;
    import lrupr_pkg::*;

    localparam int NUM_FRAMES  = 16;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_REFS = 550;

    typedef struct {
        logic [PAGE_IN_W-1:0] page;
        logic                 clr;
        logic                 last;
    } page_ref_t;

    typedef struct {
        logic                   fault;
        logic [FRAME_IDX_W-1:0] frame;
        logic                   ev_valid;
        logic [PAGE_IN_W-1:0]   ev_page;
        logic [COUNT_W-1:0]     count;
        logic                   last;
    } lru_result_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic [FRAMES_CFG_W-1:0] cfg_wr_data = '0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_W-1:0]    s_tdata = '0;
    logic [S_TUSER_W-1:0]    s_tuser = '0;
    logic                    s_tlast = 1'b0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [M_TDATA_W-1:0]    m_tdata;
    logic [M_TUSER_W-1:0]    m_tuser;
    logic                    m_tlast;

    lru_page_replacement u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // predictor state
    logic [PAGE_IN_W-1:0]    resident_page [NUM_FRAMES];
    logic                    resident_valid [NUM_FRAMES];
    int                      age_rank [NUM_FRAMES];
    int                      next_fill;
    logic [COUNT_W-1:0]      faults_so_far;
    logic [FRAMES_CFG_W-1:0] frames_cfg = FRAMES_RESET;

    page_ref_t   pending_refs [$];
    lru_result_t expected_results [$];

    logic ref_taken = 1'b0;
    int   idle_pct = 10;
    int   error_count = 0;
    int   results_seen = 0;
    int   refs_sent = 0;
    int   faults_seen = 0;
    int   evictions_seen = 0;
    int   cfg_writes = 0;
    int   stall_cycles = 0;

    function automatic void empty_frames();
        for (int i = 0; i < NUM_FRAMES; i++)
        begin
            resident_page[i]  = '0;
            resident_valid[i] = 1'b0;
            age_rank[i]       = 0;
        end
        next_fill     = 0;
        faults_so_far = '0;
    endfunction

    // age every valid frame younger than limit, then make frame k the newest
    function automatic void promote_frame(int k, int limit);
        for (int i = 0; i < NUM_FRAMES; i++)
        begin
            if (i != k && resident_valid[i] && age_rank[i] < limit &&
                age_rank[i] < NUM_FRAMES - 1)
                age_rank[i]++;
        end
        age_rank[k] = 0;
    endfunction

    function automatic lru_result_t lru_access(logic [PAGE_IN_W-1:0] page, logic clr,
                                               logic last);
        lru_result_t res;
        int          f;
        int          k;
        int          p;
        int          best;
        bit          hit;
        bit          found;

        f = frames_cfg;
        if (f < 1)
            f = 1;
        if (f > NUM_FRAMES)
            f = NUM_FRAMES;
        if (clr)
            empty_frames();

        hit = 1'b0;
        k   = 0;
        for (int i = 0; i < f; i++)
        begin
            if (!hit && resident_valid[i] && resident_page[i] == page)
            begin
                hit = 1'b1;
                k   = i;
            end
        end

        res.ev_valid = 1'b0;
        res.ev_page  = '0;
        if (hit)
            promote_frame(k, age_rank[k]);
        else
        begin
            p = (next_fill < f) ? next_fill : 0;
            if (!resident_valid[p])
            begin
                k = p;
                resident_page[k]  = page;
                resident_valid[k] = 1'b1;
                promote_frame(k, NUM_FRAMES + 1);
                next_fill = (p + 1) % f;
            end
            else
            begin
                // oldest visible frame, lowest index on a tie
                found = 1'b0;
                best  = 0;
                for (int i = 0; i < f; i++)
                begin
                    if (resident_valid[i] && (!found || age_rank[i] > best))
                    begin
                        found = 1'b1;
                        best  = age_rank[i];
                        k     = i;
                    end
                end
                res.ev_valid     = 1'b1;
                res.ev_page      = resident_page[k];
                resident_page[k] = page;
                promote_frame(k, age_rank[k]);
                next_fill = k;
            end
            if (faults_so_far != COUNT_MAX)
                faults_so_far++;
        end

        res.fault = !hit;
        res.frame = k[FRAME_IDX_W-1:0];
        res.count = faults_so_far;
        res.last  = last;
        return res;
    endfunction

    task automatic report_mismatch(string field, logic [COUNT_W-1:0] got,
                                   logic [COUNT_W-1:0] want);
        $display("[%0t] MISMATCH result %0d %s: got 0x%0h, expected 0x%0h",
                 $time, results_seen, field, got, want);
        error_count++;
    endtask

    // driver: hold the current transfer until accepted, then advance
    always @(negedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (ref_taken)
                void'(pending_refs.pop_front());
            if (s_tvalid && !ref_taken)
                s_tvalid <= 1'b1;
            else if (pending_refs.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_refs[0].page;
                s_tuser  <= pending_refs[0].clr;
                s_tlast  <= pending_refs[0].last;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        m_tready <= rst_n && ($urandom_range(99) >= idle_pct);
    end

    // monitor: predict on input transfers, check output transfers
    always @(posedge clk)
    begin : monitor
        lru_result_t want;
        if (!rst_n)
            ref_taken <= 1'b0;
        else
        begin
            ref_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
            begin
                expected_results.insert(expected_results.size(),
                                        lru_access(s_tdata[PAGE_IN_W-1:0], s_tuser[0],
                                                   s_tlast));
                refs_sent++;
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("unexpected transfer", m_tdata[COUNT_W-1:0], '0);
                else
                begin
                    want = expected_results.pop_front();
                    if (m_tuser[0] !== want.fault)
                        report_mismatch("page_fault", m_tuser[0], want.fault);
                    if (m_tdata[3:0] !== want.frame)
                        report_mismatch("frame_index", m_tdata[3:0], want.frame);
                    if (m_tuser[1] !== want.ev_valid)
                        report_mismatch("evicted_valid", m_tuser[1], want.ev_valid);
                    if (m_tdata[19:4] !== want.ev_page)
                        report_mismatch("evicted_page", m_tdata[19:4], want.ev_page);
                    if (m_tdata[51:20] !== want.count)
                        report_mismatch("fault_count", m_tdata[51:20], want.count);
                    if (m_tdata[55:52] !== 4'd0)
                        report_mismatch("tdata padding", m_tdata[55:52], '0);
                    if (m_tlast !== want.last)
                        report_mismatch("final_total", m_tlast, want.last);
                    faults_seen    += want.fault;
                    evictions_seen += want.ev_valid;
                end
                results_seen++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("[%0t] TIMEOUT: no transfer for %0d cycles, %0d results pending",
                         $time, STALL_LIMIT, expected_results.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic queue_ref(logic [PAGE_IN_W-1:0] page, logic clr, logic last);
        page_ref_t r;
        r.page = page;
        r.clr  = clr;
        r.last = last;
        pending_refs.insert(pending_refs.size(), r);
    endtask

    // hold off until the block has returned everything it owes
    task automatic wait_drained();
        while (pending_refs.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_frames(logic [FRAMES_CFG_W-1:0] value);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en  <= 1'b0;
        frames_cfg = value;
        cfg_writes++;
        @(posedge clk);
    endtask

    initial
    begin : stimulus
        logic [PAGE_IN_W-1:0] pool [20];
        int                   pool_n;
        int                   f_eff;
        int                   n_items;
        int                   phase;
        int                   pick;
        logic [PAGE_IN_W-1:0] page;
        logic [FRAMES_CFG_W-1:0] cfg_val;

        empty_frames();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset frame count: fill four frames, hit, then evict the oldest
        queue_ref(16'h0000, 1'b1, 1'b0);
        queue_ref(16'hFFFF, 1'b0, 1'b0);
        queue_ref(16'h0001, 1'b0, 1'b0);
        queue_ref(16'h0002, 1'b0, 1'b0);
        queue_ref(16'h0000, 1'b0, 1'b0);
        queue_ref(16'h0003, 1'b0, 1'b1);
        wait_drained();

        // shrink without clearing: hidden frames
        write_frames(5'd2);
        queue_ref(16'h0002, 1'b0, 1'b0);
        queue_ref(16'h0000, 1'b0, 1'b0);
        queue_ref(16'h0007, 1'b0, 1'b1);
        wait_drained();

        // zero acts as one frame
        write_frames(5'd0);
        queue_ref(16'h0009, 1'b0, 1'b0);
        queue_ref(16'h0009, 1'b0, 1'b0);
        queue_ref(16'h000A, 1'b0, 1'b0);
        wait_drained();

        // above the maximum acts as sixteen; hidden pages show up again
        write_frames(5'd31);
        queue_ref(16'h0002, 1'b0, 1'b0);
        queue_ref(16'h000A, 1'b0, 1'b0);
        queue_ref(16'h0003, 1'b0, 1'b0);
        queue_ref(16'hFFFF, 1'b0, 1'b0);
        queue_ref(16'h5A5A, 1'b0, 1'b1);
        wait_drained();

        // random phases: mostly sequences over a small page set
        phase = 0;
        while (refs_sent < RANDOM_REFS - 20)
        begin
            case (phase)
                0: cfg_val = 5'd1;
                1: cfg_val = 5'd16;
                2: cfg_val = 5'd0;
                3: cfg_val = 5'd17;
                4: cfg_val = 5'd31;
                5: cfg_val = 5'd15;
                default: cfg_val = FRAMES_CFG_W'($urandom_range(31));
            endcase
            idle_pct = (phase >= 6 && phase <= 8) ? 0 : 10;
            write_frames(cfg_val);

            f_eff = (cfg_val < 1) ? 1 : ((cfg_val > NUM_FRAMES) ? NUM_FRAMES : cfg_val);
            pool_n = f_eff + $urandom_range(4);
            for (int i = 0; i < pool_n; i++)
                pool[i] = PAGE_IN_W'($urandom);

            n_items = $urandom_range(30, 50);
            for (int i = 0; i < n_items; i++)
            begin
                pick = $urandom_range(99);
                if (pick < 85)
                    page = pool[$urandom_range(pool_n - 1)];
                else if (pick < 95)
                    page = PAGE_IN_W'($urandom);
                else
                    page = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                queue_ref(page,
                          (i == 0) ? 1'($urandom_range(1)) : ($urandom_range(99) < 3),
                          (i == n_items - 1) || ($urandom_range(99) < 5));
            end
            wait_drained();
            phase++;
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (expected_results.size() != 0)
            report_mismatch("results never returned", '0, expected_results.size());

        $display("Covered %0d references over %0d frame count settings:",
                 refs_sent, cfg_writes + 1);
        $display("%0d faults, %0d evictions, %0d results checked, %0d mismatches.",
                 faults_seen, evictions_seen, results_seen, error_count);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
